// ===== rtl/plf_pkg.sv =====
// Shared types, constants and helpers for the print line formatter.
`timescale 1ns / 1ps

package plf_pkg;

    // Printer control characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Line column counts per orientation and pitch
    localparam logic [7:0] COLS_PORT_10 = 8'd83;
    localparam logic [7:0] COLS_PORT_12 = 8'd100;
    localparam logic [7:0] COLS_PORT_15 = 8'd117;
    localparam logic [7:0] COLS_LAND_10 = 8'd113;
    localparam logic [7:0] COLS_LAND_12 = 8'd132;
    localparam logic [7:0] COLS_LAND_15 = 8'd154;
    localparam logic [7:0] MAX_COLS     = COLS_LAND_15;

    localparam int DEF_MAX_TAB_WIDTH = 16;
    localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_PITCH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE  = 3'd5;

    // Byte classes produced by the front end
    typedef enum logic [2:0] {
        OP_PRINT,
        OP_TAB,
        OP_BS,
        OP_LF,
        OP_CR,
        OP_FF,
        OP_IGNORE,
        OP_END
    } t_op;

    // Queue entry between front and back
    typedef struct packed {
        t_op        op;
        logic [7:0] glyph;
    } t_item;

    // Result record kinds
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_COMMIT = 2'd1,
        KIND_PAGE   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    // Back end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TAB,
        S_CHECK,
        S_PAGE,
        S_END
    } t_state;

    // Configuration register set
    typedef struct packed {
        logic [1:0] font_pitch;
        logic       landscape;
        logic [8:0] left_margin;
        logic [8:0] right_margin;
        logic [4:0] tab_width;
        logic       wrap_enable;
    } t_cfg;

    // Raw column count; pitch code 3 behaves as 15 cpi
    function automatic logic [7:0] line_cols(input logic landscape, input logic [1:0] pitch);
        logic [7:0] cols;
        case (pitch)
            2'd0:    cols = landscape ? COLS_LAND_10 : COLS_PORT_10;
            2'd1:    cols = landscape ? COLS_LAND_12 : COLS_PORT_12;
            default: cols = landscape ? COLS_LAND_15 : COLS_PORT_15;
        endcase
        return cols;
    endfunction

endpackage

// ===== rtl/plf_front.sv =====
// Front end: accepts text bytes and classifies them for the queue.
`timescale 1ns / 1ps

module plf_front
    import plf_pkg::*;
(
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_push,
    output t_item      o_item,
    input  logic       i_q_ready
);

    t_op op;

    // Byte classification
    always_comb begin
        if (i_end_of_text) begin
            op = OP_END;
        end else begin
            unique case (i_text_byte)
                CH_BS:   op = OP_BS;
                CH_TAB:  op = OP_TAB;
                CH_LF:   op = OP_LF;
                CH_FF:   op = OP_FF;
                CH_CR:   op = OP_CR;
                default: begin
                    if (i_text_byte >= CH_SPACE && i_text_byte <= CH_TILDE) begin
                        op = OP_PRINT;
                    end else begin
                        op = OP_IGNORE;
                    end
                end
            endcase
        end
    end

    assign o_in_ready   = i_q_ready;
    assign o_push       = i_in_valid & i_q_ready;
    assign o_item.op    = op;
    assign o_item.glyph = i_text_byte;

endmodule

// ===== rtl/plf_fifo.sv =====
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps

module plf_fifo
    import plf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/plf_back.sv =====
// Back end: line state, tab expansion, overflow handling and result register.
`timescale 1ns / 1ps

module plf_back
    import plf_pkg::*;
#(
    parameter int MAX_TAB_WIDTH = DEF_MAX_TAB_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_record_kind,
    output logic [7:0] o_position,
    output logic [7:0] o_glyph,
    output logic       o_last_of_run
);

    localparam int TW = $clog2(MAX_TAB_WIDTH + 1);

    t_state        r_state, n_state;
    logic [7:0]    r_col, n_col;
    logic          r_open, n_open;
    logic          r_aff, n_aff;
    logic          r_disc, n_disc;
    logic [TW-1:0] r_rem, n_rem;
    logic [2:0]    r_bit, n_bit;

    logic          r_out_valid;
    t_kind         r_kind;
    logic [7:0]    r_pos;
    logic [7:0]    r_glyph;
    logic          r_last;

    logic          n_emit;
    t_kind         n_kind;
    logic [7:0]    n_pos;
    logic [7:0]    n_glyph;
    logic          n_last;

    logic          out_free;
    logic [10:0]   width_diff;
    logic [7:0]    width;
    logic [TW-1:0] ts;
    logic [TW:0]   rem_shift;
    logic [TW-1:0] rem_next;
    logic [7:0]    col_inc;
    logic [7:0]    col_bs;
    logic [TW-1:0] phase_inc;

    // Usable line width, clamped to one column
    assign width_diff = 11'(line_cols(i_cfg.landscape, i_cfg.font_pitch))
                      - 11'(i_cfg.left_margin) - 11'(i_cfg.right_margin);
    assign width = (width_diff[10] || width_diff == 11'd0) ? 8'd1 : width_diff[7:0];

    // Tab stop spacing, saturated
    always_comb begin
        if (i_cfg.tab_width == 5'd0) begin
            ts = TW'(1);
        end else if (int'(i_cfg.tab_width) > MAX_TAB_WIDTH) begin
            ts = TW'(MAX_TAB_WIDTH);
        end else begin
            ts = TW'(i_cfg.tab_width);
        end
    end

    // One restoring step of column modulo tab spacing
    assign rem_shift = {r_rem, r_col[r_bit]};
    assign rem_next  = (rem_shift >= {1'b0, ts}) ? TW'(rem_shift - {1'b0, ts})
                                                 : TW'(rem_shift);

    assign out_free  = !r_out_valid || i_out_ready;
    assign col_inc   = r_col + 8'd1;
    assign col_bs    = (r_col != 8'd0) ? r_col - 8'd1 : r_col;
    assign phase_inc = r_rem + TW'(1);

    // Sequencer: next state and result selection
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_open  = r_open;
        n_aff   = r_aff;
        n_disc  = r_disc;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_emit  = 1'b0;
        n_kind  = KIND_WRITE;
        n_pos   = 8'd0;
        n_glyph = 8'd0;
        n_last  = 1'b0;
        o_q_pop = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.op == OP_END) begin
                        if (r_open && !r_disc && !r_aff) begin
                            n_emit  = 1'b1;
                            n_kind  = KIND_COMMIT;
                            n_pos   = r_col;
                            n_state = S_END;
                        end else begin
                            n_emit = 1'b1;
                            n_kind = KIND_END;
                            n_last = 1'b1;
                        end
                        n_col  = 8'd0;
                        n_open = 1'b0;
                        n_aff  = 1'b0;
                        n_disc = 1'b0;
                    end else if (r_disc) begin
                        // skipping to end of line
                        if (i_q_item.op == OP_LF) begin
                            n_disc = 1'b0;
                            n_open = 1'b0;
                            n_col  = 8'd0;
                        end
                    end else if (r_aff && i_q_item.op == OP_LF) begin
                        // newline right after a page break writes no line
                        n_aff  = 1'b0;
                        n_open = 1'b0;
                        n_col  = 8'd0;
                    end else if (r_aff && i_q_item.op == OP_CR) begin
                        n_aff  = 1'b0;
                        n_disc = 1'b1;
                        n_col  = 8'd0;
                    end else begin
                        n_aff  = 1'b0;
                        n_open = 1'b1;
                        case (i_q_item.op)
                            OP_LF: begin
                                n_emit = 1'b1;
                                n_kind = KIND_COMMIT;
                                n_pos  = r_col;
                                n_last = 1'b1;
                                n_col  = 8'd0;
                                n_open = 1'b0;
                            end
                            OP_CR: begin
                                n_emit = 1'b1;
                                n_kind = KIND_COMMIT;
                                n_pos  = r_col;
                                n_last = 1'b1;
                                n_col  = 8'd0;
                                n_disc = 1'b1;
                            end
                            OP_BS: begin
                                if (col_bs >= width) begin
                                    n_emit = 1'b1;
                                    n_kind = KIND_COMMIT;
                                    n_pos  = col_bs;
                                    n_last = 1'b1;
                                    n_col  = 8'd0;
                                    n_disc = !i_cfg.wrap_enable;
                                end else begin
                                    n_col = col_bs;
                                end
                            end
                            OP_TAB: begin
                                n_rem   = '0;
                                n_bit   = 3'd7;
                                n_state = S_MOD;
                            end
                            OP_PRINT: begin
                                n_emit  = 1'b1;
                                n_kind  = KIND_WRITE;
                                n_pos   = r_col;
                                n_glyph = i_q_item.glyph;
                                n_last  = (col_inc < width);
                                n_col   = col_inc;
                                if (col_inc >= width) begin
                                    n_state = S_CHECK;
                                end
                            end
                            default: begin
                                // page break, unless a second form feed in a row
                                if (i_q_item.op == OP_FF && !r_aff) begin
                                    n_emit = 1'b1;
                                    n_col  = 8'd0;
                                    n_aff  = 1'b1;
                                    if (r_col != 8'd0) begin
                                        n_kind  = KIND_COMMIT;
                                        n_pos   = r_col;
                                        n_state = S_PAGE;
                                    end else begin
                                        n_kind = KIND_PAGE;
                                        n_last = 1'b1;
                                    end
                                end else if (r_col >= width) begin
                                    n_emit = 1'b1;
                                    n_kind = KIND_COMMIT;
                                    n_pos  = r_col;
                                    n_last = 1'b1;
                                    n_col  = 8'd0;
                                    n_disc = !i_cfg.wrap_enable;
                                end
                            end
                        endcase
                    end
                end
            end
            S_MOD: begin
                n_rem = rem_next;
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    n_state = S_TAB;
                end
            end
            S_TAB: begin
                if (out_free) begin
                    n_emit = 1'b1;
                    if (r_col >= width) begin
                        // overflow inside the tab ends it
                        n_kind  = KIND_COMMIT;
                        n_pos   = r_col;
                        n_last  = 1'b1;
                        n_col   = 8'd0;
                        n_disc  = !i_cfg.wrap_enable;
                        n_state = S_IDLE;
                    end else begin
                        n_kind  = KIND_WRITE;
                        n_pos   = r_col;
                        n_glyph = CH_SPACE;
                        n_col   = col_inc;
                        n_rem   = phase_inc;
                        if (phase_inc == ts) begin
                            if (col_inc >= width) begin
                                n_state = S_CHECK;
                            end else begin
                                n_last  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    n_emit  = 1'b1;
                    n_kind  = KIND_COMMIT;
                    n_pos   = r_col;
                    n_last  = 1'b1;
                    n_col   = 8'd0;
                    n_disc  = !i_cfg.wrap_enable;
                    n_state = S_IDLE;
                end
            end
            S_PAGE: begin
                if (out_free) begin
                    n_emit  = 1'b1;
                    n_kind  = KIND_PAGE;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_emit  = 1'b1;
                    n_kind  = KIND_END;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= 8'd0;
            r_open  <= 1'b0;
            r_aff   <= 1'b0;
            r_disc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_open  <= n_open;
            r_aff   <= n_aff;
            r_disc  <= n_disc;
        end
    end

    // Tab remainder working registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_bit <= n_bit;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && n_emit) begin
            r_kind  <= n_kind;
            r_pos   <= n_pos;
            r_glyph <= n_glyph;
            r_last  <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_record_kind = r_kind;
    assign o_position    = r_pos;
    assign o_glyph       = r_glyph;
    assign o_last_of_run = r_last;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= MAX_COLS)
        else $error("column beyond widest line");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_disc && r_aff))
        else $error("discard and page-start flags both set");
    a_tab_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAB) |-> (r_rem < ts))
        else $error("tab phase out of range");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && n_emit && n_last) |=> (r_state == S_IDLE))
        else $error("final result issued while request still running");
`endif

endmodule

// ===== rtl/print_line_formatter.sv =====
// Top level of the print line formatter: config registers, front, queue, back.
`timescale 1ns / 1ps

// Text bytes enter through a classifying front end and a two-entry queue; a
// back-end sequencer holds the line state and issues at most one result per
// cycle into an output register. A byte yields one result, none or two (a
// form feed or end marker that commits a line, or a printable byte that fills
// the line). A tab is dispatched, then the column modulo the tab spacing is
// found by restoring steps (one remainder bit per cycle), then spaces are
// written one at a time up to the next tab stop, with a trailing line commit
// if the line fills. The back-end sequencer and
// its single result register set the rate; a stalled output holds it.
// Configuration writes take effect at once and should be made while idle.

module print_line_formatter
    import plf_pkg::*;
#(
    parameter int MAX_TAB_WIDTH = DEF_MAX_TAB_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_record_kind,
    output logic [7:0]            o_position,
    output logic [7:0]            o_glyph,
    output logic                  o_last_of_run,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  push;
    t_item front_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.font_pitch   <= 2'd0;
            r_cfg.landscape    <= 1'b0;
            r_cfg.left_margin  <= 9'd0;
            r_cfg.right_margin <= 9'd0;
            r_cfg.tab_width    <= TAB_WIDTH_RESET;
            r_cfg.wrap_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FONT_PITCH:   r_cfg.font_pitch   <= i_cfg_data[1:0];
                REG_LANDSCAPE:    r_cfg.landscape    <= i_cfg_data[0];
                REG_LEFT_MARGIN:  r_cfg.left_margin  <= i_cfg_data[8:0];
                REG_RIGHT_MARGIN: r_cfg.right_margin <= i_cfg_data[8:0];
                REG_TAB_WIDTH:    r_cfg.tab_width    <= i_cfg_data[4:0];
                REG_WRAP_ENABLE:  r_cfg.wrap_enable  <= i_cfg_data[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    plf_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_item        (front_item),
        .i_q_ready     (q_ready)
    );

    plf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    plf_back #(
        .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_record_kind (o_record_kind),
        .o_position    (o_position),
        .o_glyph       (o_glyph),
        .o_last_of_run (o_last_of_run)
    );

endmodule
